// ===== sv/fcsr_pkg.sv =====
// Shared types and constants of the filled-circle span rasterizer.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package fcsr_pkg;

  // Widths of the stream payloads, padded to whole bytes.
  localparam int unsigned IN_W  = 40;
  localparam int unsigned OUT_W = 80;

  // Internal signed width of rows and columns: a 9-bit center plus or minus
  // the radius, with one sign bit to spare.
  localparam int unsigned CW = 12;

  // Midpoint decision constants.
  localparam int D_INIT = 3;
  localparam int D_DIAG = 10;
  localparam int D_AXIS = 6;

  // Job queue geometry.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = 1;

  // One classified circle request, as it sits in the job queue.
  typedef struct packed {
    logic [15:0] colour;
    logic [4:0]  radius;
    logic [7:0]  cy;
    logic [8:0]  cx;
  } job_t;

endpackage

`default_nettype wire

// ===== sv/fcsr_front.sv =====
// Front stage: accepts circle requests, unpacks them and saturates the radius.
// Depends on fcsr_pkg.
`default_nettype none

module fcsr_front
  import fcsr_pkg::*;
#(
  parameter int unsigned MAX_RADIUS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_valid_i,
  output logic                 s_ready_o,
  input  wire logic [IN_W-1:0] s_data_i,
  output logic                 m_valid_o,
  input  wire logic            m_ready_i,
  output job_t                 m_job_o
);

  localparam logic [4:0] RMax = 5'(MAX_RADIUS);

  logic valid_q, valid_d;
  job_t job_q, job_d;

  always_comb begin
    job_d.cx     = s_data_i[8:0];
    job_d.cy     = s_data_i[16:9];
    job_d.colour = s_data_i[37:22];
    // A radius beyond the supported size is clamped to the largest one.
    job_d.radius = (s_data_i[21:17] > RMax) ? RMax : s_data_i[21:17];
  end

  assign s_ready_o = !valid_q || m_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (s_valid_i && s_ready_o) begin
      valid_d = 1'b1;
    end else if (m_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      job_q <= job_d;
    end
  end

  assign m_valid_o = valid_q;
  assign m_job_o   = job_q;

endmodule

`default_nettype wire

// ===== sv/fcsr_job_fifo.sv =====
// Short job queue between the request front end and the span walker.
// Depends on fcsr_pkg.
`default_nettype none

module fcsr_job_fifo
  import fcsr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic wr_valid_i,
  output logic      wr_ready_o,
  input  wire job_t wr_job_i,
  output logic      rd_valid_o,
  input  wire logic rd_ready_i,
  output job_t      rd_job_o
);

  job_t            slots_q [QDEPTH];
  logic [QAW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QAW:0]    count_q, count_d;
  logic            push, pop;

  assign wr_ready_o = (count_q != (QAW+1)'(QDEPTH));
  assign rd_valid_o = (count_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_job_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/fcsr_walker.sv =====
// Back end: walks the midpoint circle of one job and emits one span per cycle
// into an output register while that register is free. Depends on fcsr_pkg.
`default_nettype none

module fcsr_walker
  import fcsr_pkg::*;
#(
  parameter int unsigned MAX_RADIUS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [31:0]      frame_base_i,
  input  wire logic             job_valid_i,
  output logic                  job_ready_o,
  input  wire job_t             job_i,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  output logic [OUT_W-1:0]      m_data_o,
  output logic                  m_last_o
);

  // x runs up to about 0.71 of the radius, y from the radius down to -1.
  localparam int unsigned XYW = $clog2(MAX_RADIUS + 2) + 1;
  localparam int unsigned DW  = XYW + 5;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  state_e                 state_q;
  logic signed [XYW-1:0]  x_q, y_q;
  logic signed [DW-1:0]   d_q;
  logic [1:0]             phase_q;
  logic [8:0]             cx_q;
  logic [7:0]             cy_q;
  logic [15:0]            colour_q;
  logic                   out_valid_q;
  logic [OUT_W-1:0]       out_data_q;
  logic                   out_last_q;

  logic                   slot_free;
  logic signed [CW-1:0]   xe, ye, cxe, cye, reach, off;
  logic signed [CW-1:0]   row, col_a, col_b, left;
  logic [CW-1:0]          span_len;
  logic [31:0]            row32, left32, addr;
  logic                   more;
  logic signed [XYW-1:0]  x_n, y_n;
  logic signed [DW-1:0]   xd_n, yd_n, d_n, d_init;
  logic [OUT_W-1:0]       span_data;

  assign slot_free   = !out_valid_q || m_ready_i;
  assign job_ready_o = (state_q == ST_IDLE);

  // Span geometry. Phases 0 and 1 use rows cy+y and cy-y over half-width x,
  // phases 2 and 3 use rows cy+x and cy-x over half-width y.
  always_comb begin
    xe    = {{(CW-XYW){x_q[XYW-1]}}, x_q};
    ye    = {{(CW-XYW){y_q[XYW-1]}}, y_q};
    cxe   = {{(CW-9){1'b0}}, cx_q};
    cye   = {{(CW-8){1'b0}}, cy_q};
    reach = phase_q[1] ? ye : xe;
    off   = phase_q[1] ? xe : ye;
    row   = phase_q[0] ? (cye - off) : (cye + off);
    col_a = cxe - reach;
    col_b = cxe + reach;
    if (col_a < col_b) begin
      left     = col_a;
      span_len = col_b - col_a;
    end else begin
      left     = col_b;
      span_len = col_a - col_b;
    end
    row32  = {{(32-CW){row[CW-1]}}, row};
    left32 = {{(32-CW){left[CW-1]}}, left};
    addr   = frame_base_i + (row32 << 10) + (left32 << 1);
    span_data = {6'b0, colour_q, addr, span_len[5:0], left[9:0], row[9:0]};
  end

  // Midpoint step taken after the last span of a point.
  always_comb begin
    more  = (y_q >= x_q);
    x_n   = x_q + 1'b1;
    y_n   = (d_q > 0) ? (y_q - 1'b1) : y_q;
    xd_n  = {{(DW-XYW){x_n[XYW-1]}}, x_n};
    yd_n  = {{(DW-XYW){y_n[XYW-1]}}, y_n};
    if (d_q > 0) begin
      d_n = d_q + ((xd_n - yd_n) <<< 2) + $signed(DW'(D_DIAG));
    end else begin
      d_n = d_q + (xd_n <<< 2) + $signed(DW'(D_AXIS));
    end
    d_init = $signed(DW'(D_INIT)) - $signed(DW'(job_i.radius) << 1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (job_valid_i) begin
            state_q <= ST_RUN;
            phase_q <= '0;
          end
        end
        ST_RUN: begin
          if (slot_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= span_data;
            out_last_q  <= (phase_q == 2'd3) && !more;
            phase_q     <= phase_q + 1'b1;
            if ((phase_q == 2'd3) && !more) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && job_valid_i) begin
      cx_q     <= job_i.cx;
      cy_q     <= job_i.cy;
      colour_q <= job_i.colour;
      x_q      <= '0;
      y_q      <= XYW'(job_i.radius);
      d_q      <= d_init;
    end else if ((state_q == ST_RUN) && slot_free) begin
      if ((phase_q == 2'd3) && more) begin
        x_q <= x_n;
        y_q <= y_n;
        d_q <= d_n;
      end
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_data_q;
  assign m_last_o  = out_last_q;

endmodule

`default_nettype wire

// ===== sv/filled_circle_span_rasterizer.sv =====
// Top level of the filled-circle span rasterizer: frame base register, front
// end, job queue and span walker. Depends on fcsr_pkg and the fcsr_* modules.
`default_nettype none

// A request carries a circle center, a radius and an RGB565 colour; the block
// answers with the horizontal spans that fill the circle, four per point of
// the midpoint circle walk, the last one flagged by tlast. Each span gives its
// row, leftmost column, length (the right end pixel is not included), its
// frame byte address frame_base + (row << 10) + (left << 1) and the colour.
// Rows and columns are not clipped; a radius above MAX_RADIUS is clamped.
// Timing: the span walker produces one span per cycle into its output
// register while that register is free to take it, and it loads the next
// job only once it has emitted the last span of the current one. The front
// end and the two-entry job queue take new requests while the walker is busy;
// a stalled output holds the walker and, once the queue and front end are full,
// new requests. frame_base is written through the configuration channel,
// which is always ready; it must only change while no circle is in flight.

module filled_circle_span_rasterizer
  import fcsr_pkg::*;
#(
  parameter int unsigned MAX_RADIUS = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // Configuration channel: frame_base write data.
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [31:0]      cfg_data_i,
  // Circle requests.
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // center_x [8:0], center_y [16:9], radius [21:17], fill_colour [37:22]
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  // Span results.
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // span_row [9:0], span_left [19:10], span_length [25:20],
  // span_address [57:26], span_colour [73:58]
  output logic [OUT_W-1:0]      m_axis_tdata,
  output logic                  m_axis_tlast
);

  logic [31:0] frame_base_q;

  logic front_valid, front_ready;
  job_t front_job;
  logic queue_valid, queue_ready;
  job_t queue_job;

  // The base register takes every request on the configuration channel.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_base_q <= '0;
    end else if (cfg_valid_i) begin
      frame_base_q <= cfg_data_i;
    end
  end

  fcsr_front #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid),
    .s_ready_o(s_axis_tready),
    .s_data_i (s_axis_tdata),
    .m_valid_o(front_valid),
    .m_ready_i(front_ready),
    .m_job_o  (front_job)
  );

  fcsr_job_fifo u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(front_valid),
    .wr_ready_o(front_ready),
    .wr_job_i  (front_job),
    .rd_valid_o(queue_valid),
    .rd_ready_i(queue_ready),
    .rd_job_o  (queue_job)
  );

  fcsr_walker #(
    .MAX_RADIUS(MAX_RADIUS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frame_base_i(frame_base_q),
    .job_valid_i (queue_valid),
    .job_ready_o (queue_ready),
    .job_i       (queue_job),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule

`default_nettype wire

// ===== verif/fcsr_span_checker.sv =====
`timescale 1ns / 1ps
// Span checker for the filled-circle span rasterizer: watches the frame base,
// request and span channels, predicts each span and compares. Uses fcsr_pkg.

module fcsr_span_checker
  import fcsr_pkg::*;
#(
  parameter int MAX_RADIUS = 16,
  parameter int SPAN_LIMIT = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [IN_W-1:0]  s_tdata_i,
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  input  logic [OUT_W-1:0] m_tdata_i,
  input  logic             m_tlast_i,
  output int               mismatches_o,
  output int               pending_o
);

  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  left;
    logic [5:0]  length;
    logic [31:0] address;
    logic [15:0] colour;
    logic        last;
  } span_t;

  span_t       expected_spans[$];
  logic [31:0] frame_base;
  span_t       got;
  span_t       want;
  int          span_count;

  // One horizontal span between columns a and b, right end pixel excluded.
  task automatic push_span(input int row, input int a, input int b,
                           input logic [15:0] colour, input bit last);
    span_t s;
    int    left_col;
    left_col  = (a < b) ? a : b;
    s.row     = 10'(row);
    s.left    = 10'(left_col);
    s.length  = 6'((a < b) ? (b - a) : (a - b));
    // The address uses the full coordinates, not the 10-bit wrapped ones.
    s.address = frame_base + 32'(row <<< 10) + 32'(left_col <<< 1);
    s.colour  = colour;
    s.last    = last;
    expected_spans.push_back(s);
  endtask

  // Midpoint circle walk, four spans per point.
  task automatic queue_circle_spans(input logic [IN_W-1:0] req);
    int          xc;
    int          yc;
    int          r;
    int          x;
    int          y;
    int          d;
    int          n;
    bit          final_pt;
    logic [15:0] colour;
    xc     = int'(req[8:0]);
    yc     = int'(req[16:9]);
    r      = int'(req[21:17]);
    colour = req[37:22];
    if (r > MAX_RADIUS) r = MAX_RADIUS;
    x = 0;
    y = r;
    d = D_INIT - 2 * r;
    n = 0;
    final_pt = 1'b0;
    while (!final_pt && n + 4 <= SPAN_LIMIT) begin
      // The walk ends after a point at which y has fallen below x, or once the next point would pass SPAN_LIMIT.
      final_pt = (y < x) || (n + 8 > SPAN_LIMIT);
      push_span(yc + y, xc - x, xc + x, colour, 1'b0);
      push_span(yc - y, xc - x, xc + x, colour, 1'b0);
      push_span(yc + x, xc - y, xc + y, colour, 1'b0);
      push_span(yc - x, xc - y, xc + y, colour, final_pt);
      n += 4;
      if (!final_pt) begin
        x++;
        if (d > 0) begin
          y--;
          d = d + 4 * (x - y) + D_DIAG;
        end else begin
          d = d + 4 * x + D_AXIS;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_spans.delete();
      frame_base   = '0;
      mismatches_o = 0;
      span_count   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) frame_base = cfg_data_i;
      if (s_tvalid_i && s_tready_i) queue_circle_spans(s_tdata_i);
      if (m_tvalid_i && m_tready_i) begin
        got.row     = m_tdata_i[9:0];
        got.left    = m_tdata_i[19:10];
        got.length  = m_tdata_i[25:20];
        got.address = m_tdata_i[57:26];
        got.colour  = m_tdata_i[73:58];
        got.last    = m_tlast_i;
        span_count++;
        if (expected_spans.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("span %0d arrived with no span expected: %p", span_count, got);
        end else begin
          want = expected_spans.pop_front();
          if (got !== want) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display("span %0d mismatch: expected row %0d left %0d len %0d",
                       span_count, $signed(want.row), $signed(want.left), want.length,
                       " addr %h colour %h last %b; got row %0d left %0d len %0d",
                       want.address, want.colour, want.last,
                       $signed(got.row), $signed(got.left), got.length,
                       " addr %h colour %h last %b",
                       got.address, got.colour, got.last);
          end
        end
      end
    end
    pending_o = expected_spans.size();
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the filled-circle span rasterizer testbench: clock, reset, request
// and span stimulus, verdict. Needs fcsr_pkg, the block and fcsr_span_checker.

module tb_top;
  import fcsr_pkg::*;

  localparam int MAX_GAP      = 4;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int PHASE_ITEMS  = 87;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [31:0]      cfg_data_i;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic             m_axis_tlast;

  int mismatches;
  int pending;

  // When set, neither side idles; used for back-to-back stretches.
  bit quiet;
  // Set by the request side to make the span side hold off for a long while.
  bit hold_req;

  filled_circle_span_rasterizer #(
    .MAX_RADIUS(16)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  fcsr_span_checker #(
    .MAX_RADIUS(16),
    .SPAN_LIMIT(64)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tlast_i   (m_axis_tlast),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Frame base write; only issued while no circle is in flight.
  task automatic write_frame_base(input logic [31:0] value);
    @(negedge clk_i);
    cfg_data_i  = value;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Offers one circle request after a random gap (none while quiet) and returns once it has
  // been accepted. Valid stays high into the next request when the gap is 0.
  task automatic send_circle(input logic [8:0] cx, input logic [7:0] cy,
                             input logic [4:0] radius, input logic [15:0] colour);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tdata  = {2'b00, colour, radius, cy, cx};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stops offering requests until every predicted span has come out.
  task automatic wait_for_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(posedge clk_i);
  endtask

  // Random circles: mostly on-screen centers and in-range radii, with some
  // centers past the screen edge and saturating radii.
  task automatic run_random_phase(input int phase_no, input int count);
    logic [8:0]  cx;
    logic [7:0]  cy;
    logic [4:0]  radius;
    for (int i = 0; i < count; i++) begin
      quiet = (i >= count / 3) && (i < count / 3 + 15);
      if (phase_no == 1 && i == 10) hold_req = 1'b1;
      cx     = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(320, 511))
                                           : 9'($urandom_range(0, 319));
      cy     = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(240, 255))
                                           : 8'($urandom_range(0, 239));
      radius = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(17, 31))
                                           : 5'($urandom_range(0, 16));
      send_circle(cx, cy, radius, 16'($urandom));
    end
    quiet = 1'b0;
  endtask

  // Span side: random stalls between spans, plus one long hold-off on
  // request so the job queue fills and the request side is backpressured.
  initial begin : span_sink
    int unsigned stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (stall > 0) begin
          @(negedge clk_i);
          m_axis_tready = 1'b0;
          repeat (stall - 1) @(negedge clk_i);
        end
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("filled_circle_span_rasterizer test failed");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] bases[5];
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    quiet         = 1'b0;
    hold_req      = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed circles: corners of the screen (negative rows and columns),
    // zero radius, saturating radii, centers past the edge of the screen,
    // and all-zero / all-one colours.
    write_frame_base(32'($urandom));
    send_circle(9'd0,   8'd0,   5'd0,  16'h0000);
    send_circle(9'd319, 8'd239, 5'd16, 16'hFFFF);
    send_circle(9'd511, 8'd255, 5'd31, 16'hAAAA);
    send_circle(9'd160, 8'd120, 5'd1,  16'h5555);
    send_circle(9'd160, 8'd120, 5'd2,  16'hF800);
    send_circle(9'd0,   8'd239, 5'd16, 16'h07E0);
    send_circle(9'd319, 8'd0,   5'd16, 16'h001F);
    send_circle(9'd320, 8'd128, 5'd5,  16'h1234);
    send_circle(9'd256, 8'd100, 5'd17, 16'hFEDC);
    send_circle(9'd100, 8'd200, 5'd15, 16'h8001);
    quiet = 1'b1;
    send_circle(9'd8,   8'd8,   5'd3,  16'h7FFE);
    send_circle(9'd511, 8'd0,   5'd0,  16'hFFFF);
    send_circle(9'd0,   8'd255, 5'd31, 16'h0000);
    send_circle(9'd200, 8'd50,  5'd4,  16'hC3C3);
    send_circle(9'd1,   8'd1,   5'd1,  16'h3C3C);
    send_circle(9'd480, 8'd130, 5'd10, 16'h0F0F);
    quiet = 1'b0;
    send_circle(9'd160, 8'd120, 5'd16, 16'hF0F0);
    send_circle(9'd300, 8'd16,  5'd0,  16'h9999);
    wait_for_idle();

    // Random phases, each under its own frame base; the extremes first.
    bases[0] = 32'h0000_0000;
    bases[1] = 32'hFFFF_FFFF;
    bases[2] = 32'h8000_0000;
    bases[3] = 32'($urandom);
    bases[4] = 32'($urandom);
    for (int p = 0; p < 5; p++) begin
      write_frame_base(bases[p]);
      run_random_phase(p, PHASE_ITEMS);
      wait_for_idle();
    end

    // Let any stray span surface before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("filled_circle_span_rasterizer test passed");
    end else begin
      $display("filled_circle_span_rasterizer test failed");
    end
    $finish;
  end

endmodule
